FILE: hdl/srg_pkg.sv
package srg_pkg;

	localparam int unsigned WordW = 64;

	typedef logic [WordW-1:0] word_t;
	typedef logic [1:0]       opcode_t;

	localparam opcode_t OP_RESEED  = 2'd0;
	localparam opcode_t OP_BOUNDED = 2'd1;
	localparam opcode_t OP_RAW     = 2'd2;

	localparam word_t GOLDEN_ADD   = 64'h9E37_79B9_7F4A_7C15;
	localparam word_t MIX_MUL_A    = 64'hBF58_476D_1CE4_E5B9;
	localparam word_t MIX_MUL_B    = 64'h94D0_49BB_1331_11EB;
	localparam word_t FALLBACK     = 64'h1066_89D4_5497_FDB5;
	localparam word_t SCRAMBLE_MUL = 64'd2685821657736338717;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_RS_W1,
		ST_RS_G2,
		ST_RS_W2,
		ST_RS_G3,
		ST_RS_W3,
		ST_MOD_LIM,
		ST_DRAW,
		ST_MOD_RES,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic busy;
		logic done;
	} unit_sts_t;

	function automatic word_t xorshift_step(word_t s);
		word_t x;
		x = s ^ (s >> 12);
		x = x ^ (x << 25);
		x = x ^ (x >> 27);
		return x;
	endfunction

endpackage

FILE: hdl/srg_in_if.sv
interface srg_in_if;
	logic              valid;
	logic              ready;
	srg_pkg::opcode_t  opcode;
	srg_pkg::word_t    seed_value;
	srg_pkg::word_t    stream_index;
	srg_pkg::word_t    bound;

	modport source (output valid, output opcode, output seed_value, output stream_index,
		output bound, input ready);
	modport sink (input valid, input opcode, input seed_value, input stream_index,
		input bound, output ready);
endinterface

FILE: hdl/srg_out_if.sv
interface srg_out_if;
	logic           valid;
	logic           ready;
	srg_pkg::word_t random_value;

	modport source (output valid, output random_value, input ready);
	modport sink (input valid, input random_value, output ready);
endinterface

FILE: hdl/srg_mul.sv
module srg_mul (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  srg_pkg::word_t       a,
	input  srg_pkg::word_t       b,
	output srg_pkg::word_t       product,
	output srg_pkg::unit_sts_t   sts
);

	localparam int unsigned CntW = $clog2(srg_pkg::WordW);

	srg_pkg::word_t  a_q;
	srg_pkg::word_t  b_q;
	srg_pkg::word_t  acc_q;
	logic [CntW-1:0] cnt_q;
	logic            busy_q;
	logic            done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == '1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// One multiplier bit per cycle; the product is kept modulo 2^64.
	always_ff @(posedge clk) begin
		if (start) begin
			a_q   <= a;
			b_q   <= b;
			acc_q <= '0;
		end else if (busy_q) begin
			if (b_q[0]) begin
				acc_q <= acc_q + a_q;
			end
			a_q <= a_q << 1;
			b_q <= b_q >> 1;
		end
	end

	assign product  = acc_q;
	assign sts.busy = busy_q;
	assign sts.done = done_q;

endmodule

FILE: hdl/srg_mod.sv
module srg_mod (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  srg_pkg::word_t       dividend,
	input  srg_pkg::word_t       divisor,
	output srg_pkg::word_t       remainder,
	output srg_pkg::unit_sts_t   sts
);

	localparam int unsigned CntW = $clog2(srg_pkg::WordW);

	srg_pkg::word_t        dvd_q;
	srg_pkg::word_t        div_q;
	srg_pkg::word_t        rem_q;
	logic [CntW-1:0]       cnt_q;
	logic                  busy_q;
	logic                  done_q;
	logic [srg_pkg::WordW:0] trial;
	logic [srg_pkg::WordW:0] diff;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == '1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Restoring remainder: the partial remainder stays below the divisor, so
	// after the shift it needs one extra bit and one conditional subtract.
	assign trial = {rem_q, dvd_q[srg_pkg::WordW-1]};
	assign diff  = trial - {1'b0, div_q};

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			div_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= dvd_q << 1;
			if (!diff[srg_pkg::WordW]) begin
				rem_q <= diff[srg_pkg::WordW-1:0];
			end else begin
				rem_q <= trial[srg_pkg::WordW-1:0];
			end
		end
	end

	assign remainder = rem_q;
	assign sts.busy  = busy_q;
	assign sts.done  = done_q;

endmodule

FILE: hdl/seeded_bounded_random_generator.sv
// Channel  Modport  Payload                                     Role
// item     sink     opcode, seed_value, stream_index, bound     requests in
// result   source   random_value                                one word per draw
//
// Multiplies and remainders run one bit per cycle through a shared serial
// multiplier and a shared serial remainder unit.
// A raw draw uses one multiply; a reseed uses three multiplies. A bounded draw uses a
// remainder, a multiply per word drawn, and a remainder; a zero bound gives zero.
// Reset loads the fallback seed; a finished result waits in an output register
// while the next request is accepted.
module seeded_bounded_random_generator (
	input  logic       clk,
	input  logic       arst_n,
	srg_in_if.sink     item,
	srg_out_if.source  result
);

	srg_pkg::state_t    state_q;
	srg_pkg::state_t    state_d;
	srg_pkg::word_t     gen_q;
	srg_pkg::word_t     s_q;
	srg_pkg::word_t     b_q;
	srg_pkg::word_t     x_q;
	srg_pkg::word_t     m_q;
	srg_pkg::word_t     res_q;
	srg_pkg::word_t     out_data_q;
	logic               out_valid_q;
	logic               raw_q;

	logic               accept;
	logic               step_en;
	logic               slot_free;
	logic               reject;
	srg_pkg::word_t     gen_next;
	srg_pkg::word_t     mix_out;

	logic               mul_start;
	srg_pkg::word_t     mul_a;
	srg_pkg::word_t     mul_b;
	srg_pkg::word_t     mul_p;
	srg_pkg::unit_sts_t mul_sts;

	logic               mod_start;
	srg_pkg::word_t     mod_a;
	srg_pkg::word_t     mod_b;
	srg_pkg::word_t     mod_r;
	srg_pkg::unit_sts_t mod_sts;

	srg_mul u_mul (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (mul_start),
		.a       (mul_a),
		.b       (mul_b),
		.product (mul_p),
		.sts     (mul_sts)
	);

	srg_mod u_mod (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (mod_start),
		.dividend  (mod_a),
		.divisor   (mod_b),
		.remainder (mod_r),
		.sts       (mod_sts)
	);

	assign item.ready          = (state_q == srg_pkg::ST_IDLE);
	assign accept              = item.valid && item.ready;
	assign slot_free           = !out_valid_q || result.ready;
	assign gen_next            = srg_pkg::xorshift_step(gen_q);
	assign reject              = (mul_p >= m_q);
	assign mix_out             = mul_p ^ (mul_p >> 31);
	assign result.valid        = out_valid_q;
	assign result.random_value = out_data_q;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			srg_pkg::ST_IDLE: begin
				if (accept) begin
					case (item.opcode)
						srg_pkg::OP_RESEED:  state_d = srg_pkg::ST_RS_W1;
						srg_pkg::OP_BOUNDED: begin
							state_d = (item.bound == '0) ? srg_pkg::ST_OUT
								: srg_pkg::ST_MOD_LIM;
						end
						srg_pkg::OP_RAW:     state_d = srg_pkg::ST_DRAW;
						default:             state_d = srg_pkg::ST_IDLE;
					endcase
				end
			end
			srg_pkg::ST_RS_W1:   if (mul_sts.done) state_d = srg_pkg::ST_RS_G2;
			srg_pkg::ST_RS_G2:   state_d = srg_pkg::ST_RS_W2;
			srg_pkg::ST_RS_W2:   if (mul_sts.done) state_d = srg_pkg::ST_RS_G3;
			srg_pkg::ST_RS_G3:   state_d = srg_pkg::ST_RS_W3;
			srg_pkg::ST_RS_W3:   if (mul_sts.done) state_d = srg_pkg::ST_IDLE;
			srg_pkg::ST_MOD_LIM: if (mod_sts.done) state_d = srg_pkg::ST_DRAW;
			srg_pkg::ST_DRAW: begin
				if (mul_sts.done) begin
					if (raw_q) begin
						state_d = srg_pkg::ST_OUT;
					end else if (!reject) begin
						state_d = srg_pkg::ST_MOD_RES;
					end
				end
			end
			srg_pkg::ST_MOD_RES: if (mod_sts.done) state_d = srg_pkg::ST_OUT;
			srg_pkg::ST_OUT:     if (slot_free) state_d = srg_pkg::ST_IDLE;
			default:             state_d = srg_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		step_en   = 1'b0;
		mul_start = 1'b0;
		mul_a     = gen_next;
		mul_b     = srg_pkg::SCRAMBLE_MUL;
		mod_start = 1'b0;
		mod_a     = mul_p;
		mod_b     = b_q;
		unique case (state_q)
			srg_pkg::ST_IDLE: begin
				if (accept) begin
					case (item.opcode)
						srg_pkg::OP_RESEED: begin
							mul_start = 1'b1;
							mul_a     = item.stream_index;
							mul_b     = srg_pkg::MIX_MUL_A;
						end
						srg_pkg::OP_BOUNDED: begin
							mod_start = (item.bound != '0);
							mod_a     = '1;
							mod_b     = item.bound;
						end
						srg_pkg::OP_RAW: begin
							step_en   = 1'b1;
							mul_start = 1'b1;
						end
						default: ;
					endcase
				end
			end
			srg_pkg::ST_RS_G2: begin
				mul_start = 1'b1;
				mul_a     = x_q ^ (x_q >> 30);
				mul_b     = srg_pkg::MIX_MUL_A;
			end
			srg_pkg::ST_RS_G3: begin
				mul_start = 1'b1;
				mul_a     = x_q ^ (x_q >> 27);
				mul_b     = srg_pkg::MIX_MUL_B;
			end
			srg_pkg::ST_MOD_LIM: begin
				step_en   = mod_sts.done;
				mul_start = mod_sts.done;
			end
			srg_pkg::ST_DRAW: begin
				// A rejected word starts the next step at once.
				if (mul_sts.done && !raw_q) begin
					step_en   = reject;
					mul_start = reject;
					mod_start = !reject;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= srg_pkg::ST_IDLE;
			gen_q       <= srg_pkg::FALLBACK;
			out_valid_q <= 1'b0;
			raw_q       <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				raw_q <= (item.opcode == srg_pkg::OP_RAW);
			end
			if (step_en) begin
				gen_q <= gen_next;
			end else if (state_q == srg_pkg::ST_RS_W3 && mul_sts.done) begin
				gen_q <= (mix_out == '0) ? srg_pkg::FALLBACK : mix_out;
			end
			if (state_q == srg_pkg::ST_OUT && slot_free) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			s_q <= item.seed_value;
			b_q <= item.bound;
		end
		if (state_q == srg_pkg::ST_RS_W1 && mul_sts.done) begin
			x_q <= s_q + srg_pkg::GOLDEN_ADD + mul_p;
		end else if (state_q == srg_pkg::ST_RS_W2 && mul_sts.done) begin
			x_q <= mul_p;
		end
		// Largest multiple of the bound not above 2^64-1 is all-ones minus the remainder.
		if (state_q == srg_pkg::ST_MOD_LIM && mod_sts.done) begin
			m_q <= ~mod_r;
		end
		if (accept) begin
			res_q <= '0;
		end else if (state_q == srg_pkg::ST_DRAW && mul_sts.done) begin
			res_q <= mul_p;
		end else if (state_q == srg_pkg::ST_MOD_RES && mod_sts.done) begin
			res_q <= mod_r;
		end
		if (state_q == srg_pkg::ST_OUT && slot_free) begin
			out_data_q <= res_q;
		end
	end

`ifndef SYNTHESIS
	a_state_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		gen_q != '0)
		else $error("generator state became zero");

	a_mul_start_free: assert property (@(posedge clk) disable iff (!arst_n)
		mul_start |-> !mul_sts.busy)
		else $error("multiplier started while busy");

	a_mod_start_free: assert property (@(posedge clk) disable iff (!arst_n)
		mod_start |-> !mod_sts.busy)
		else $error("remainder unit started while busy");

	a_ready_units_idle: assert property (@(posedge clk) disable iff (!arst_n)
		item.ready |-> (!mul_sts.busy && !mod_sts.busy))
		else $error("request accepted while an arithmetic unit is busy");

	a_mod_done_state: assert property (@(posedge clk) disable iff (!arst_n)
		mod_sts.done |-> (state_q == srg_pkg::ST_MOD_LIM || state_q == srg_pkg::ST_MOD_RES))
		else $error("remainder finished outside a remainder state");
`endif

endmodule

FILE: tb/sv/tb.sv
module tb;

	localparam srg_pkg::opcode_t OP_UNUSED   = 2'd3;
	localparam int               NUM_RANDOM  = 1350;
	localparam int               NUM_ROWS    = 22;
	localparam int               HOLD_AT     = 300;
	localparam int               HOLD_CYCLES = 600;
	localparam int               TAIL_CYCLES = 400;
	localparam int               IDLE_LIMIT  = 20000;

	typedef struct packed {
		srg_pkg::opcode_t op;
		srg_pkg::word_t   seed;
		srg_pkg::word_t   idx;
		srg_pkg::word_t   bnd;
		logic             typed;
		srg_pkg::word_t   typed_val;
	} req_t;

	// Expected values are typed in only for draws whose answer is obvious; every other
	// row goes through the predictor.
	localparam req_t DIRECTED [NUM_ROWS] = '{
		'{srg_pkg::OP_RAW,     '0, '0, '0, 1'b0, '0},
		'{srg_pkg::OP_BOUNDED, '1, '1, '0, 1'b1, '0},
		'{srg_pkg::OP_BOUNDED, '0, '0, 64'd1, 1'b1, '0},
		'{srg_pkg::OP_BOUNDED, '0, '0, '1, 1'b0, '0},
		'{srg_pkg::OP_BOUNDED, '0, '0, 64'h8000_0000_0000_0000, 1'b0, '0},
		'{srg_pkg::OP_BOUNDED, '0, '0, 64'h8000_0000_0000_0001, 1'b0, '0},
		'{srg_pkg::OP_BOUNDED, '0, '0, 64'd2, 1'b0, '0},
		'{OP_UNUSED,           '1, '1, '1, 1'b0, '0},
		'{srg_pkg::OP_RAW,     '0, '0, '0, 1'b0, '0},
		'{srg_pkg::OP_RESEED,  '0, '0, '0, 1'b0, '0},
		'{srg_pkg::OP_RAW,     '0, '0, '0, 1'b0, '0},
		'{srg_pkg::OP_RESEED,  '1, '1, '1, 1'b0, '0},
		'{srg_pkg::OP_BOUNDED, '0, '0, 64'd10, 1'b0, '0},
		'{srg_pkg::OP_RESEED,  64'h61C8_8646_80B5_83EB, '0, '0, 1'b0, '0},
		'{srg_pkg::OP_RAW,     '0, '0, '0, 1'b0, '0},
		'{srg_pkg::OP_BOUNDED, '1, '1, 64'd1, 1'b1, '0},
		'{srg_pkg::OP_RESEED,  64'h0123_4567_89AB_CDEF, 64'd1, '0, 1'b0, '0},
		'{srg_pkg::OP_BOUNDED, '0, '0, 64'd3, 1'b0, '0},
		'{srg_pkg::OP_RAW,     '1, '1, '1, 1'b0, '0},
		'{OP_UNUSED,           '0, '0, '0, 1'b0, '0},
		'{srg_pkg::OP_BOUNDED, 64'h5555_5555_5555_5555, '0,
			64'h7FFF_FFFF_FFFF_FFFF, 1'b0, '0},
		'{srg_pkg::OP_RAW,     '0, '0, '0, 1'b0, '0}
	};

	logic clk;
	logic arst_n;

	srg_in_if  item ();
	srg_out_if result ();

	seeded_bounded_random_generator u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item),
		.result (result)
	);

	srg_pkg::word_t gen_state;
	srg_pkg::word_t expected_draws[$];
	int             errors;
	int             n_accepted;
	int             idle_cycles;
	bit             hold_request;
	bit             requests_done;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic srg_pkg::word_t rand_word();
		return {$urandom, $urandom};
	endfunction

	function automatic srg_pkg::word_t seed_hash(srg_pkg::word_t s, srg_pkg::word_t k);
		srg_pkg::word_t x;
		x = s + srg_pkg::GOLDEN_ADD + k * srg_pkg::MIX_MUL_A;
		x = x ^ (x >> 30);
		x = x * srg_pkg::MIX_MUL_A;
		x = x ^ (x >> 27);
		x = x * srg_pkg::MIX_MUL_B;
		x = x ^ (x >> 31);
		return x;
	endfunction

	function automatic srg_pkg::word_t next_word();
		srg_pkg::word_t x;
		x = gen_state;
		x = x ^ (x >> 12);
		x = x ^ (x << 25);
		x = x ^ (x >> 27);
		gen_state = x;
		return x * srg_pkg::SCRAMBLE_MUL;
	endfunction

	function automatic srg_pkg::word_t draw_below(srg_pkg::word_t b);
		srg_pkg::word_t lim;
		srg_pkg::word_t w;
		if (b == '0) begin
			return '0;
		end
		lim = srg_pkg::word_t'('1) - (srg_pkg::word_t'('1) % b);
		w = next_word();
		while (w >= lim) begin
			w = next_word();
		end
		return w % b;
	endfunction

	task automatic predict_draw(input req_t r, output bit has, output srg_pkg::word_t val);
		srg_pkg::word_t mixed;
		has = 1'b0;
		val = '0;
		case (r.op)
			srg_pkg::OP_RESEED: begin
				mixed = seed_hash(r.seed, r.idx);
				gen_state = (mixed != '0) ? mixed : srg_pkg::FALLBACK;
			end
			srg_pkg::OP_BOUNDED: begin
				has = 1'b1;
				val = draw_below(r.bnd);
			end
			srg_pkg::OP_RAW: begin
				has = 1'b1;
				val = next_word();
			end
			default: ;
		endcase
	endtask

	function automatic srg_pkg::word_t rand_bound();
		srg_pkg::word_t b;
		case ($urandom_range(0, 9))
			0: b = '0;
			1: b = 64'd1;
			2, 3: b = srg_pkg::word_t'($urandom_range(2, 1000));
			4: b = srg_pkg::word_t'(1) << $urandom_range(0, 63);
			// Just above half the range, so about half the words are rejected.
			5: b = (srg_pkg::word_t'(1) << 63) + srg_pkg::word_t'($urandom_range(0, 1000));
			6: b = srg_pkg::word_t'('1) - srg_pkg::word_t'($urandom_range(0, 1000));
			default: b = rand_word() >> $urandom_range(0, 63);
		endcase
		return b;
	endfunction

	function automatic srg_pkg::word_t rand_seed();
		srg_pkg::word_t s;
		case ($urandom_range(0, 7))
			0: s = '0;
			1: s = '1;
			2: s = rand_word() >> $urandom_range(1, 63);
			default: s = rand_word();
		endcase
		return s;
	endfunction

	function automatic req_t random_req();
		req_t r;
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 15) begin
			r.op = srg_pkg::OP_RESEED;
		end else if (pick < 55) begin
			r.op = srg_pkg::OP_BOUNDED;
		end else if (pick < 95) begin
			r.op = srg_pkg::OP_RAW;
		end else begin
			r.op = OP_UNUSED;
		end
		r.seed = rand_seed();
		r.idx = rand_seed();
		r.bnd = rand_bound();
		r.typed = 1'b0;
		r.typed_val = '0;
		return r;
	endfunction

	task automatic flag_mismatch(input string what, input srg_pkg::word_t got,
		input srg_pkg::word_t want);
		errors++;
		$display("mismatch at %0t: %s got %h want %h", $time, what, got, want);
	endtask

	initial begin : drive_requests
		req_t           r;
		bit             has;
		srg_pkg::word_t val;
		int             row;
		int             counted;
		int             burst_left;
		int             gap;
		item.valid <= 1'b0;
		item.opcode <= srg_pkg::OP_RESEED;
		item.seed_value <= '0;
		item.stream_index <= '0;
		item.bound <= '0;
		gen_state = srg_pkg::FALLBACK;
		row = 0;
		counted = 0;
		burst_left = 0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		while (row < NUM_ROWS || counted < NUM_RANDOM) begin
			r = (row < NUM_ROWS) ? DIRECTED[row] : random_req();
			if (burst_left == 0) begin
				gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
				if (gap > 0) begin
					item.valid <= 1'b0;
					repeat (gap) @(posedge clk);
				end
				burst_left = $urandom_range(1, 24);
			end
			item.valid <= 1'b1;
			item.opcode <= r.op;
			item.seed_value <= r.seed;
			item.stream_index <= r.idx;
			item.bound <= r.bnd;
			// Ready seen at the falling edge holds through the next rising edge.
			@(negedge clk);
			while (!item.ready) @(negedge clk);
			@(posedge clk);
			predict_draw(r, has, val);
			if (has) begin
				expected_draws.insert(expected_draws.size(), r.typed ? r.typed_val : val);
			end
			if (row >= NUM_ROWS && r.op != OP_UNUSED) begin
				counted++;
			end
			row++;
			burst_left--;
			n_accepted++;
			if (n_accepted == HOLD_AT) begin
				hold_request = 1'b1;
			end
		end
		item.valid <= 1'b0;
		requests_done = 1'b1;
	end

	initial begin : drive_result_ready
		int  hold_left;
		int  mode;
		int  mode_left;
		bit  hold_done;
		logic rdy;
		result.ready <= 1'b0;
		hold_left = 0;
		hold_done = 1'b0;
		mode = 0;
		mode_left = 100;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (hold_left > 0) begin
				hold_left--;
				rdy = 1'b0;
			end else if (hold_request && !hold_done) begin
				// Long hold-off while requests keep coming, so the block backs up.
				hold_done = 1'b1;
				hold_left = HOLD_CYCLES - 1;
				rdy = 1'b0;
			end else begin
				case (mode)
					0: rdy = 1'b1;
					1: rdy = $urandom_range(0, 1);
					2: rdy = ($urandom_range(0, 3) == 0);
					default: rdy = ($urandom_range(0, 4) != 0);
				endcase
			end
			result.ready <= rdy;
			mode_left--;
			if (mode_left == 0) begin
				mode = $urandom_range(0, 3);
				mode_left = $urandom_range(50, 400);
			end
		end
	end

	always @(negedge clk) begin : check_draws
		srg_pkg::word_t want;
		if (arst_n && result.valid && result.ready) begin
			if (expected_draws.size() == 0) begin
				flag_mismatch("unexpected random_value", result.random_value, '0);
			end else begin
				want = expected_draws.pop_front();
				if (result.random_value !== want) begin
					flag_mismatch("random_value", result.random_value, want);
				end
			end
		end
	end

	always @(negedge clk) begin
		if (arst_n) begin
			if ((item.valid && item.ready) || (result.valid && result.ready)) begin
				idle_cycles = 0;
			end else begin
				idle_cycles++;
			end
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("timeout after %0d idle cycles", idle_cycles);
				$display("SCOREBOARD MISMATCH");
				$finish;
			end
		end
	end

	initial begin : run_control
		errors = 0;
		n_accepted = 0;
		idle_cycles = 0;
		hold_request = 1'b0;
		requests_done = 1'b0;
		arst_n = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		wait (requests_done);
		while (expected_draws.size() != 0) @(negedge clk);
		// Let a trailing reseed or ignored request finish; a stray result is flagged.
		repeat (TAIL_CYCLES) @(negedge clk);
		if (errors == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule
